>>> hw/rtl/gprn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gprn_pkg;
  localparam int GROUP_PIXELS = 8;
  localparam int LANES = 4;
  localparam int MOD_STEPS = 8;
  localparam logic [31:0] LANE_MULT [LANES] = '{32'd214013, 32'd17405, 32'd214013, 32'd69069};
  localparam logic [31:0] LANE_ADD [LANES] = '{32'd2531011, 32'd10395331, 32'd13737667, 32'd1};
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_B = 16'd7471;
  localparam logic [8:0] GATE_MOD = 9'd100;
  localparam logic [6:0] LIMIT_RST = 7'd60;
  localparam logic [7:0] AMP_RST = 8'd120;
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_AMP = 1'b1;
  localparam logic [1:0] SET_GATE = 2'd0;
  localparam logic [1:0] SET_SIGN = 2'd1;
  localparam logic [1:0] SET_RAISE = 2'd2;
  localparam logic [1:0] SET_LOWER = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP0, S_STEP1, S_LOAD, S_MOD, S_WR, S_LUMA, S_FIN
  } state_t;

  typedef struct packed {
    logic       in_load;
    logic       lane_step;
    logic       cap_hi;
    logic       mod_load;
    logic       mod_step;
    logic       store_wr;
    logic [1:0] set;
    logic [2:0] idx;
    logic       luma_en;
    logic       out_load;
    logic [2:0] word;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/gray_pixel_random_noise.sv
// Inside a group a beat is captured in S_IDLE, summed to luma in S_LUMA and loaded
// out in S_FIN; a group's first pixel adds a refill of 4 x (2 LCG steps + 8 modulo
// passes via S_LOAD, S_MOD, S_WR), mostly set by the 4-bit-per-cycle remainder unit.
// A new pixel is taken only in S_IDLE, after the last is loaded out; S_FIN holds on stall.
// Reset: synchronous active-low; seeds and group position clear, limit 60, amp 120.
`timescale 1ns / 1ps
`default_nettype none
module gray_pixel_random_noise (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // blue_in, green_in, red_in
  input  wire logic        in_tuser,  // first_of_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // gray_out
  output logic             out_tuser, // noise_applied
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import gprn_pkg::*;

  cmd_t cmd;
  stat_t stat;

  gprn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .in_first(in_tuser),
    .cmd(cmd), .stat(stat), .in_ready(in_tready)
  );

  gprn_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .pix(in_tdata), .out_valid(out_tvalid), .out_ready(out_tready),
    .gray(out_tdata), .applied(out_tuser)
  );
endmodule
`default_nettype wire

>>> hw/rtl/gprn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gprn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          in_first,
  output gprn_pkg::cmd_t     cmd,
  input  gprn_pkg::stat_t    stat,
  output logic               in_ready
);
  import gprn_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] cur_r, cur_nxt;
  logic [1:0] set_r, set_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] bitc_r, bitc_nxt;
  logic [2:0] p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r <= '0;
      cur_r <= '0;
      set_r <= '0;
      idx_r <= '0;
      bitc_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      cur_r <= cur_nxt;
      set_r <= set_nxt;
      idx_r <= idx_nxt;
      bitc_r <= bitc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    cur_nxt = cur_r;
    set_nxt = set_r;
    idx_nxt = idx_r;
    bitc_nxt = bitc_r;
    cmd = '0;
    cmd.set = set_r;
    cmd.idx = idx_r;
    cmd.word = ~cur_r;
    in_ready = 1'b0;
    p = in_first ? 3'd0 : pos_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.in_load = 1'b1;
          cur_nxt = p;
          set_nxt = '0;
          idx_nxt = '0;
          state_nxt = (p == 3'd0) ? S_STEP0 : S_LUMA;
        end
      end
      S_STEP0: begin
        cmd.lane_step = 1'b1;
        state_nxt = S_STEP1;
      end
      S_STEP1: begin
        cmd.lane_step = 1'b1;
        cmd.cap_hi = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.mod_load = 1'b1;
        bitc_nxt = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        bitc_nxt = bitc_r + 3'd1;
        if (bitc_r == 3'(MOD_STEPS - 1)) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.store_wr = 1'b1;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'(GROUP_PIXELS - 1)) begin
          set_nxt = set_r + 2'd1;
          state_nxt = (set_r == SET_LOWER) ? S_LUMA : S_STEP0;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LUMA: begin
        cmd.luma_en = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          pos_nxt = cur_r + 3'd1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/gprn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gprn_dp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  gprn_pkg::cmd_t   cmd,
  output gprn_pkg::stat_t  stat,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic [23:0] pix,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       gray,
  output logic             applied
);
  import gprn_pkg::*;

  logic [6:0] limit_r;
  logic [7:0] amp_r;
  logic [31:0] seed_r [LANES];
  logic [31:0] seed_nxt [LANES];
  logic [31:0] wbuf_r [GROUP_PIXELS];
  logic [31:0] sh_r;
  logic [8:0] rem_r;
  logic [6:0] gate_r [GROUP_PIXELS];
  logic       sign_r [GROUP_PIXELS];
  logic [7:0] raise_r [GROUP_PIXELS];
  logic [7:0] lower_r [GROUP_PIXELS];
  logic [7:0] b_r, g_r, r_r;
  logic [23:0] luma_r;
  logic out_valid_r;
  logic [7:0] gray_r;
  logic applied_r;
  logic [8:0] modulus;
  logic [9:0] t;
  logic [8:0] rem_nxt;
  logic [31:0] sh_nxt;
  logic [24:0] v, d;
  logic hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      amp_r <= AMP_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LIMIT) limit_r <= cfg_wdata[6:0];
      else amp_r <= cfg_wdata;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++)
      seed_nxt[l] = seed_r[l] * LANE_MULT[l] + LANE_ADD[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) seed_r[l] <= '0;
    end else if (cmd.lane_step) begin
      for (int l = 0; l < LANES; l++) seed_r[l] <= seed_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lane_step) begin
      for (int l = 0; l < LANES; l++) begin
        if (cmd.cap_hi) wbuf_r[LANES + l] <= seed_nxt[l];
        else wbuf_r[l] <= seed_nxt[l];
      end
    end
  end

  assign modulus = (cmd.set == SET_GATE) ? GATE_MOD : {1'b0, amp_r} + 9'd1;

  always_comb begin
    rem_nxt = rem_r;
    sh_nxt = sh_r;
    for (int i = 0; i < 4; i++) begin
      t = {rem_nxt, sh_nxt[31]};
      sh_nxt = {sh_nxt[30:0], 1'b0};
      if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
      rem_nxt = t[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      sh_r <= wbuf_r[cmd.idx];
      rem_r <= '0;
    end else if (cmd.mod_step) begin
      sh_r <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      case (cmd.set)
        SET_GATE:  gate_r[cmd.idx] <= rem_r[6:0];
        SET_SIGN:  sign_r[cmd.idx] <= wbuf_r[cmd.idx][0];
        SET_RAISE: raise_r[cmd.idx] <= rem_r[7:0];
        default:   lower_r[cmd.idx] <= rem_r[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      b_r <= pix[7:0];
      g_r <= pix[15:8];
      r_r <= pix[23:16];
    end
    if (cmd.luma_en)
      luma_r <= 24'(r_r * COEF_R) + 24'(g_r * COEF_G) + 24'(b_r * COEF_B);
  end

  always_comb begin
    d = '0;
    hit = gate_r[cmd.word] <= limit_r;
    v = {1'b0, luma_r};
    if (hit) begin
      if (!sign_r[cmd.word]) begin
        d = {1'b0, lower_r[cmd.word], 16'd0};
        v = (d >= v) ? 25'd0 : v - d;
      end else begin
        v = v + {1'b0, raise_r[cmd.word], 16'd0};
      end
    end
    if (v > {1'b0, 8'd255, 16'd0}) v = {1'b0, 8'd255, 16'd0};
    v = v + 25'h8000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gray_r <= v[23:16];
      applied_r <= hit;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign gray = gray_r;
  assign applied = applied_r;
endmodule
`default_nettype wire
